>>> hw/rtl/otse_pkg.sv
// Shared types, constants and helpers of the ordered target statistic encoder.
package otse_pkg;

  localparam int CATEGORY_SLOTS = 1024;
  localparam int MAX_CLASSES    = 4;
  localparam int ROW_BITS       = 20;
  localparam int CAT_W          = $clog2(CATEGORY_SLOTS);
  localparam int CNT_W          = 20;
  localparam int ROWS_W         = 21;
  localparam int SUM_W          = 52;
  localparam int DIV_NUM_W      = 60;
  localparam int DIV_DEN_W      = 43;
  localparam int DIV_Q_W        = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ADDR_W         = 5;

  localparam logic [19:0] ROW_MASK = (ROW_BITS >= 20) ? 20'hFFFFF : 20'((1 << ROW_BITS) - 1);
  localparam logic [SUM_W-1:0] ONE_Q16 = SUM_W'(65536);

  localparam logic [2:0] REG_CTR_MODE   = 3'd0;
  localparam logic [2:0] REG_STRENGTH   = 3'd1;
  localparam logic [2:0] REG_CLASS_CNT  = 3'd2;
  localparam logic [2:0] REG_PRIOR0     = 3'd3;
  localparam logic [2:0] REG_PRIOR1     = 3'd4;
  localparam logic [2:0] REG_PRIOR2     = 3'd5;
  localparam logic [2:0] REG_PRIOR3     = 3'd6;

  localparam logic OP_COUNT  = 1'b0;
  localparam logic OP_ENCODE = 1'b1;
  localparam logic MODE_MEAN = 1'b0;

  typedef struct packed {
    logic               operation;
    logic [9:0]         category;
    logic signed [31:0] label;
    logic [19:0]        row_number;
  } item_t;

  typedef struct packed {
    logic [19:0]        row_out;
    logic [1:0]         column;
    logic signed [31:0] encoded_value;
    logic               last;
  } result_t;

  // Request as classified by the front end.
  typedef struct packed {
    logic               op;
    logic [CAT_W-1:0]   cat;
    logic signed [31:0] label;
    logic [19:0]        row;
    logic [1:0]         cls;
    logic               cls_ok;
  } work_t;

  typedef struct packed {
    logic                      ctr_mode;
    logic [15:0]               strength;
    logic [2:0]                class_count;
    logic [3:0][31:0]          prior;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LOAD, ST_M_PROD, ST_M_NUM,
    ST_F_MUL1, ST_F_MUL2, ST_F_MUL3, ST_F_NUM, ST_DIV, ST_EMIT, ST_UPDATE
  } back_state_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

>>> hw/rtl/otse_fifo.sv
// Small register queue with full and empty flags.
module otse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end
endmodule

>>> hw/rtl/otse_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module otse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  otse_pkg::item_t   item,
  input  logic              clearing,
  output logic              full,
  input  logic              work_pop,
  output otse_pkg::work_t   work,
  output logic              work_empty
);
  otse_pkg::work_t cls_item;
  logic            queue_full;
  logic            neg;
  logic [32:0]     mag;
  logic [16:0]     rounded;

  // Round the label half away from zero to find its class.
  always_comb begin
    neg     = item.label[31];
    mag     = neg ? 33'(-{item.label[31], item.label}) : {1'b0, item.label};
    rounded = 17'((mag + 33'd32768) >> 16);
    cls_item.op     = item.operation;
    cls_item.cat    = otse_pkg::CAT_W'(item.category);
    cls_item.label  = item.label;
    cls_item.row    = item.row_number & otse_pkg::ROW_MASK;
    cls_item.cls    = rounded[1:0];
    cls_item.cls_ok = (!neg || rounded == '0) && (rounded < 17'(otse_pkg::MAX_CLASSES));
  end

  assign full = queue_full || clearing;

  otse_fifo #(
    .WIDTH($bits(otse_pkg::work_t)),
    .DEPTH(otse_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (push && !full),
    .wdata(cls_item),
    .rd   (work_pop),
    .rdata(work),
    .full (queue_full),
    .empty(work_empty)
  );
endmodule

>>> hw/rtl/otse_div.sv
// Restoring divider, one quotient bit per cycle, with overflow flag.
module otse_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [otse_pkg::DIV_NUM_W-1:0] num,
  input  logic [otse_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [otse_pkg::DIV_Q_W-1:0]   quo,
  output logic                           ovf
);
  localparam int NW   = otse_pkg::DIV_NUM_W;
  localparam int DW   = otse_pkg::DIV_DEN_W;
  localparam int QW   = otse_pkg::DIV_Q_W;
  localparam int SW   = DW + QW - 1;
  localparam int CNTW = $clog2(QW);

  logic [NW-1:0]   rem;
  logic [SW-1:0]   dsh;
  logic            busy;
  logic [CNTW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf <= ((SW + 1)'(num) >= {den, {QW{1'b0}}});
      rem <= num;
      dsh <= {den, {(QW-1){1'b0}}};
      quo <= '0;
    end else if (busy) begin
      if (SW'(rem) >= dsh) begin
        rem <= rem - dsh[NW-1:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        quo <= {quo[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end
endmodule

>>> hw/rtl/otse_back.sv
// Back end: statistic tables, per-class sequencing, division and table update.
module otse_back (
  input  logic             clk,
  input  logic             rst,
  input  otse_pkg::cfg_t   cfg,
  input  otse_pkg::work_t  work,
  input  logic             work_empty,
  output logic             work_pop,
  output logic             clearing,
  output logic             res_push,
  output otse_pkg::result_t res,
  input  logic             res_full
);
  localparam int CW = otse_pkg::CAT_W;
  localparam int NC = otse_pkg::MAX_CLASSES;
  localparam int SW = otse_pkg::SUM_W;

  typedef logic [NC-1:0][SW-1:0] sum_row_t;

  otse_pkg::back_state_t state, state_next;
  otse_pkg::work_t       job;

  logic [otse_pkg::CNT_W-1:0] cnt_mem  [otse_pkg::CATEGORY_SLOTS];
  logic [otse_pkg::CNT_W-1:0] gcnt_mem [otse_pkg::CATEGORY_SLOTS];
  sum_row_t                   sum_mem  [otse_pkg::CATEGORY_SLOTS];
  logic [otse_pkg::CNT_W-1:0] cnt_rd, gcnt_rd;
  sum_row_t                   sum_rd;

  logic                       cnt_we, gcnt_we, sum_we;
  logic [CW-1:0]              waddr;
  logic [otse_pkg::CNT_W-1:0] cnt_wd, gcnt_wd;
  sum_row_t                   sum_wd;

  logic [CW-1:0]               clr_idx;
  logic [otse_pkg::ROWS_W-1:0] counted, seen;
  logic [1:0]                  k;
  logic [2:0]                  ncls;
  logic                        is_last;
  logic [20:0]                 d_mean;
  logic [21:0]                 dd;
  logic signed [48:0]          prod;
  logic [40:0]                 p1;
  logic [35:0]                 p2;
  logic [42:0]                 den_r;
  logic                        neg;

  logic                              div_start, div_go, div_done, div_ovf;
  logic [otse_pkg::DIV_NUM_W-1:0]    div_num;
  logic [otse_pkg::DIV_DEN_W-1:0]    div_den;
  logic [otse_pkg::DIV_Q_W-1:0]      div_q;

  logic [20:0]        n_plus_s;
  logic [21:0]        s_plus_s;
  logic signed [53:0] num_m;
  logic [53:0]        mag_m;
  logic [41:0]        sum_f;
  logic [31:0]        value;

  always_comb begin
    if (cfg.class_count == 3'd0) begin
      ncls = 3'd1;
    end else if (cfg.class_count > 3'(NC)) begin
      ncls = 3'(NC);
    end else begin
      ncls = cfg.class_count;
    end
    is_last  = (cfg.ctr_mode != otse_pkg::MODE_MEAN) || ({1'b0, k} == ncls - 3'd1);
    n_plus_s = 21'(cnt_rd) + 21'(cfg.strength);
    s_plus_s = 22'(seen) + 22'(cfg.strength);
    num_m    = 54'(signed'(sum_rd[k])) + 54'(prod);
    mag_m    = num_m[53] ? 54'(-num_m) : 54'(num_m);
    sum_f    = 42'(p1) + 42'(p2);
    // Saturate the rounded magnitude to the signed 32-bit range.
    if (neg) begin
      value = (div_ovf || div_q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-div_q);
    end else begin
      value = (div_ovf || div_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= otse_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    work_pop   = 1'b0;
    clearing   = 1'b0;
    res_push   = 1'b0;
    div_start  = 1'b0;
    cnt_we     = 1'b0;
    gcnt_we    = 1'b0;
    sum_we     = 1'b0;
    waddr      = job.cat;
    cnt_wd     = '0;
    gcnt_wd    = '0;
    sum_wd     = '0;
    unique case (state)
      otse_pkg::ST_CLEAR: begin
        clearing = 1'b1;
        cnt_we   = 1'b1;
        gcnt_we  = 1'b1;
        sum_we   = 1'b1;
        waddr    = clr_idx;
        if (clr_idx == CW'(otse_pkg::CATEGORY_SLOTS - 1)) begin
          state_next = otse_pkg::ST_IDLE;
        end
      end
      otse_pkg::ST_IDLE: begin
        if (!work_empty) begin
          work_pop   = 1'b1;
          state_next = otse_pkg::ST_READ;
        end
      end
      otse_pkg::ST_READ: state_next = otse_pkg::ST_LOAD;
      otse_pkg::ST_LOAD: begin
        if (job.op == otse_pkg::OP_COUNT) begin
          gcnt_we    = 1'b1;
          gcnt_wd    = (gcnt_rd == '1) ? gcnt_rd : gcnt_rd + 1'b1;
          state_next = otse_pkg::ST_IDLE;
        end else if (cfg.ctr_mode == otse_pkg::MODE_MEAN) begin
          state_next = otse_pkg::ST_M_PROD;
        end else begin
          state_next = otse_pkg::ST_F_MUL1;
        end
      end
      otse_pkg::ST_M_PROD: state_next = otse_pkg::ST_M_NUM;
      otse_pkg::ST_M_NUM: begin
        div_start  = 1'b1;
        state_next = otse_pkg::ST_DIV;
      end
      otse_pkg::ST_F_MUL1: state_next = otse_pkg::ST_F_MUL2;
      otse_pkg::ST_F_MUL2: state_next = otse_pkg::ST_F_MUL3;
      otse_pkg::ST_F_MUL3: state_next = otse_pkg::ST_F_NUM;
      otse_pkg::ST_F_NUM: begin
        div_start  = 1'b1;
        state_next = otse_pkg::ST_DIV;
      end
      otse_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = otse_pkg::ST_EMIT;
        end
      end
      otse_pkg::ST_EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = is_last ? otse_pkg::ST_UPDATE : otse_pkg::ST_M_PROD;
        end
      end
      otse_pkg::ST_UPDATE: begin
        cnt_we = 1'b1;
        cnt_wd = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
        sum_we = 1'b1;
        sum_wd = sum_rd;
        if (cfg.ctr_mode == otse_pkg::MODE_MEAN) begin
          if (ncls == 3'd1) begin
            sum_wd[0] = otse_pkg::sat_add(sum_rd[0], SW'(job.label));
          end else if (job.cls_ok && {1'b0, job.cls} < ncls) begin
            sum_wd[job.cls] = otse_pkg::sat_add(sum_rd[job.cls], otse_pkg::ONE_Q16);
          end
        end
        state_next = otse_pkg::ST_IDLE;
      end
      default: state_next = otse_pkg::ST_IDLE;
    endcase
  end

  assign res.row_out       = job.row;
  assign res.column        = k;
  assign res.encoded_value = value;
  assign res.last          = is_last;

  always_ff @(posedge clk) begin
    cnt_rd  <= cnt_mem[job.cat];
    gcnt_rd <= gcnt_mem[job.cat];
    sum_rd  <= sum_mem[job.cat];
    if (cnt_we) begin
      cnt_mem[waddr] <= cnt_wd;
    end
    if (gcnt_we) begin
      gcnt_mem[waddr] <= gcnt_wd;
    end
    if (sum_we) begin
      sum_mem[waddr] <= sum_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      counted <= '0;
      seen    <= '0;
      div_go  <= 1'b0;
    end else begin
      // Start the divider once its operands have been registered.
      div_go <= div_start;
      if (state == otse_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == otse_pkg::ST_LOAD && job.op == otse_pkg::OP_COUNT && counted != '1) begin
        counted <= counted + 1'b1;
      end
      if (state == otse_pkg::ST_UPDATE && seen != '1) begin
        seen <= seen + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      otse_pkg::ST_IDLE: begin
        if (work_pop) begin
          job <= work;
        end
      end
      otse_pkg::ST_LOAD: begin
        k      <= '0;
        d_mean <= (n_plus_s == '0) ? 21'd1 : n_plus_s;
        dd     <= (s_plus_s == '0) ? 22'd1 : s_plus_s;
      end
      otse_pkg::ST_M_PROD: prod <= signed'({1'b0, cfg.strength}) * signed'(cfg.prior[k]);
      otse_pkg::ST_M_NUM: begin
        neg     <= num_m[53];
        div_num <= otse_pkg::DIV_NUM_W'(mag_m) + otse_pkg::DIV_NUM_W'(d_mean >> 1);
        div_den <= otse_pkg::DIV_DEN_W'(d_mean);
      end
      otse_pkg::ST_F_MUL1: p1 <= cnt_rd * counted;
      otse_pkg::ST_F_MUL2: p2 <= cfg.strength * gcnt_rd;
      otse_pkg::ST_F_MUL3: den_r <= counted * dd;
      otse_pkg::ST_F_NUM: begin
        neg <= 1'b0;
        if (counted == '0) begin
          div_num <= otse_pkg::DIV_NUM_W'({cnt_rd, 16'b0}) + otse_pkg::DIV_NUM_W'(dd >> 1);
          div_den <= otse_pkg::DIV_DEN_W'(dd);
        end else begin
          div_num <= otse_pkg::DIV_NUM_W'({sum_f, 16'b0}) + otse_pkg::DIV_NUM_W'(den_r >> 1);
          div_den <= den_r;
        end
      end
      otse_pkg::ST_EMIT: begin
        if (res_push && !is_last) begin
          k <= k + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  otse_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q),
    .ovf  (div_ovf)
  );
endmodule

>>> hw/rtl/ordered_target_statistic_encoder.sv
// Ordered target statistic encoder: APB registers, front end, back end, result queue.
//
// Requests enter on push/full/item; results leave on empty/pop/result, oldest
// first. A count request updates the global category tally and yields nothing.
// An encode request yields one result per class in mean mode, or one in
// frequency mode, and then updates the category's count and, in mean mode, its sums.
// Each result costs one pass of the 32-step restoring divider, which holds the
// back end until done, so the back end takes no new request from its queue before
// it is through with the last one. A count request passes idle, read and load; a
// mean-mode encode then runs product, numerator, divide and emit for each class,
// and a frequency-mode encode runs three multiplies, numerator, divide and emit;
// both end with the table update. A two-entry queue sits between front and back,
// and a two-entry result queue sits at the output, so requests keep being taken
// while results wait. When pop stays low the back end holds its result and
// stops; full then rises once both queues are full. After reset the tables are
// cleared one category per cycle, all 1024 of them, with full held high;
// registers return to their defaults and may be written over APB meanwhile.
module ordered_target_statistic_encoder (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  otse_pkg::item_t          item,
  output logic                     empty,
  input  logic                     pop,
  output otse_pkg::result_t        result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [otse_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  otse_pkg::cfg_t    cfg;
  otse_pkg::work_t   work;
  otse_pkg::result_t res;
  logic              work_pop, work_empty, clearing;
  logic              res_push, res_full;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ctr_mode    <= 1'b0;
      cfg.strength    <= 16'd1;
      cfg.class_count <= 3'd1;
      cfg.prior       <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        otse_pkg::REG_CTR_MODE:  cfg.ctr_mode    <= pwdata[0];
        otse_pkg::REG_STRENGTH:  cfg.strength    <= pwdata[15:0];
        otse_pkg::REG_CLASS_CNT: cfg.class_count <= pwdata[2:0];
        otse_pkg::REG_PRIOR0:    cfg.prior[0]    <= pwdata;
        otse_pkg::REG_PRIOR1:    cfg.prior[1]    <= pwdata;
        otse_pkg::REG_PRIOR2:    cfg.prior[2]    <= pwdata;
        otse_pkg::REG_PRIOR3:    cfg.prior[3]    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      otse_pkg::REG_CTR_MODE:  prdata = {31'b0, cfg.ctr_mode};
      otse_pkg::REG_STRENGTH:  prdata = {16'b0, cfg.strength};
      otse_pkg::REG_CLASS_CNT: prdata = {29'b0, cfg.class_count};
      otse_pkg::REG_PRIOR0:    prdata = cfg.prior[0];
      otse_pkg::REG_PRIOR1:    prdata = cfg.prior[1];
      otse_pkg::REG_PRIOR2:    prdata = cfg.prior[2];
      otse_pkg::REG_PRIOR3:    prdata = cfg.prior[3];
      default:                 prdata = '0;
    endcase
  end

  otse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .clearing  (clearing),
    .full      (full),
    .work_pop  (work_pop),
    .work      (work),
    .work_empty(work_empty)
  );

  otse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .work      (work),
    .work_empty(work_empty),
    .work_pop  (work_pop),
    .clearing  (clearing),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  otse_fifo #(
    .WIDTH($bits(otse_pkg::result_t)),
    .DEPTH(otse_pkg::QUEUE_DEPTH)
  ) u_results (
    .clk  (clk),
    .rst  (rst),
    .wr   (res_push),
    .wdata(res),
    .rd   (pop),
    .rdata(result),
    .full (res_full),
    .empty(empty)
  );
endmodule

>>> dv/otse_checker.sv
// Scoreboard for the ordered target statistic encoder: watches the ports but prdata, predicts and checks.
`timescale 1ns / 100ps
module otse_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  otse_pkg::item_t   item,
  input  logic              empty,
  input  logic              pop,
  input  otse_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [otse_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                mismatches,
  output int                awaiting,
  output int                checked,
  output int                encodes
);

  localparam longint SUM_HI = 64'sh0007_FFFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int unsigned CNT_HI = 32'hF_FFFF;
  localparam int unsigned ROWS_HI = 32'h1F_FFFF;
  localparam int SLOTS = otse_pkg::CATEGORY_SLOTS;
  localparam int NCLS = otse_pkg::MAX_CLASSES;

  // shadow of the configuration registers
  logic               mode_freq;
  logic [15:0]        strength;
  logic [2:0]         classes;
  logic signed [31:0] prior [4];

  // shadow of the category tables
  int unsigned cat_seen [SLOTS];
  int unsigned cat_total [SLOTS];
  longint      label_sum [SLOTS * NCLS];
  int unsigned counted_rows;
  int unsigned rows_encoded;

  otse_pkg::result_t expected_results [$];

  function automatic logic [31:0] clamp_q16(bit neg, longint unsigned mag);
    if (neg) begin
      if (mag > 64'd2147483648) mag = 64'd2147483648;
      return 32'(-longint'(mag));
    end
    if (mag > 64'd2147483647) mag = 64'd2147483647;
    return 32'(mag);
  endfunction

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic logic [31:0] mean_value(longint num, longint unsigned den);
    bit neg;
    longint unsigned mag;
    neg = num < 0;
    mag = neg ? longint'(-num) : num;
    return clamp_q16(neg, round_div(mag, den));
  endfunction

  task automatic predict_request(otse_pkg::item_t it);
    int unsigned cat, ncls, k, cls;
    longint unsigned s, n, t, g, d, num, den, mag;
    longint acc;
    bit neg;
    otse_pkg::result_t r;
    cat = it.category % SLOTS;
    if (it.operation == otse_pkg::OP_COUNT) begin
      if (cat_total[cat] < CNT_HI) cat_total[cat]++;
      if (counted_rows < ROWS_HI) counted_rows++;
      return;
    end
    encodes++;
    ncls = (classes < 1) ? 1 : (classes > NCLS) ? NCLS : classes;
    s = strength;
    n = cat_seen[cat];
    r.row_out = it.row_number & otse_pkg::ROW_MASK;
    if (mode_freq == otse_pkg::MODE_MEAN) begin
      d = (n + s < 1) ? 1 : n + s;
      for (k = 0; k < ncls; k++) begin
        acc = label_sum[cat * NCLS + k] + longint'(s) * longint'(prior[k]);
        r.column = 2'(k);
        r.encoded_value = mean_value(acc, d);
        r.last = (k == ncls - 1);
        expected_results.insert(expected_results.size(), r);
      end
      if (ncls == 1) begin
        acc = label_sum[cat * NCLS] + longint'(it.label);
        label_sum[cat * NCLS] = (acc > SUM_HI) ? SUM_HI : (acc < SUM_LO) ? SUM_LO : acc;
      end else begin
        neg = it.label < 0;
        mag = neg ? -longint'(it.label) : longint'(it.label);
        cls = int'((mag + 32768) >> 16);
        // negative labels that round to a nonzero class are dropped
        if (!(neg && cls != 0) && cls < ncls) begin
          acc = label_sum[cat * NCLS + cls] + 65536;
          label_sum[cat * NCLS + cls] = (acc > SUM_HI) ? SUM_HI : acc;
        end
      end
    end else begin
      t = counted_rows;
      g = cat_total[cat];
      d = (rows_encoded + s < 1) ? 1 : rows_encoded + s;
      if (t == 0) begin
        num = n * 65536;
        den = d;
      end else begin
        num = (n * t + s * g) * 65536;
        den = t * d;
      end
      r.column = 2'd0;
      r.encoded_value = clamp_q16(0, round_div(num, den));
      r.last = 1'b1;
      expected_results.insert(expected_results.size(), r);
    end
    if (cat_seen[cat] < CNT_HI) cat_seen[cat]++;
    if (rows_encoded < ROWS_HI) rows_encoded++;
  endtask

  always @(posedge clk) begin
    otse_pkg::result_t e;
    if (rst) begin
      mode_freq <= otse_pkg::MODE_MEAN;
      strength <= 16'd1;
      classes <= 3'd1;
      for (int i = 0; i < 4; i++) prior[i] <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        cat_seen[i] = 0;
        cat_total[i] = 0;
      end
      for (int i = 0; i < SLOTS * NCLS; i++) label_sum[i] = 0;
      counted_rows = 0;
      rows_encoded = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          otse_pkg::REG_CTR_MODE:  mode_freq <= pwdata[0];
          otse_pkg::REG_STRENGTH:  strength <= pwdata[15:0];
          otse_pkg::REG_CLASS_CNT: classes <= pwdata[2:0];
          otse_pkg::REG_PRIOR0:    prior[0] <= pwdata;
          otse_pkg::REG_PRIOR1:    prior[1] <= pwdata;
          otse_pkg::REG_PRIOR2:    prior[2] <= pwdata;
          otse_pkg::REG_PRIOR3:    prior[3] <= pwdata;
          default: ;
        endcase
      end
      if (push && !full) predict_request(item);
      if (pop && !empty) begin
        checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $error("result for row %0d arrived with nothing expected", result.row_out);
        end else begin
          e = expected_results.pop_front();
          if (result.row_out !== e.row_out) begin
            mismatches++;
            $error("row_out: expected %0d, got %0d", e.row_out, result.row_out);
          end
          if (result.column !== e.column) begin
            mismatches++;
            $error("column: expected %0d, got %0d", e.column, result.column);
          end
          if (result.encoded_value !== e.encoded_value) begin
            mismatches++;
            $error("encoded_value: expected %0d, got %0d", e.encoded_value,
                   result.encoded_value);
          end
          if (result.last !== e.last) begin
            mismatches++;
            $error("last: expected %0d, got %0d", e.last, result.last);
          end
        end
      end
    end
  end

  assign awaiting = expected_results.size();

endmodule

>>> dv/testbench.sv
// Top of the encoder testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 100ps
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  otse_pkg::item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  otse_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [otse_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int mismatches, awaiting, checked, encodes;
  int cycles = 0;
  int burst_left = 0;
  int sent = 0;
  bit hold_request = 0;
  bit hold_done = 0;

  ordered_target_statistic_encoder dut (.*);

  otse_checker scoreboard (
    .clk, .rst, .push, .full, .item, .empty, .pop, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .awaiting, .checked, .encodes
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: pop pattern rotates through always, half random and rare; one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1;
      end
      case ((cycles / 64) % 3)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 1) == 1);
        default: pop <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one request; bursts of back-to-back requests with random gaps between.
  task automatic send(otse_pkg::item_t it);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (awaiting != 0);
    repeat (80) @(posedge clk);
  endtask

  function automatic otse_pkg::item_t make(logic op, logic [9:0] cat, logic [31:0] lab,
                                           logic [19:0] row);
    otse_pkg::item_t it;
    it.operation = op;
    it.category = cat;
    it.label = lab;
    it.row_number = row;
    return it;
  endfunction

  function automatic otse_pkg::item_t random_request();
    otse_pkg::item_t it;
    int cls;
    it.operation = ($urandom_range(0, 9) < 3) ? otse_pkg::OP_COUNT : otse_pkg::OP_ENCODE;
    it.category = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 7)) : 10'($urandom);
    case ($urandom_range(0, 3))
      0: it.label = $urandom;
      1: it.label = 32'(int'($urandom_range(0, 262143)) - 131072);
      default: begin
        // class-like label with jitter, some rounding outside the class range
        cls = int'($urandom_range(0, 5)) - 1;
        it.label = 32'(cls * 65536 + int'($urandom_range(0, 65535)) - 32768);
      end
    endcase
    it.row_number = 20'($urandom);
    return it;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send(random_request());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // mean encoding, one output, default registers
    send(make(otse_pkg::OP_ENCODE, 10'd0, 32'h7FFF_FFFF, 20'd0));
    send(make(otse_pkg::OP_ENCODE, 10'd0, 32'h7FFF_FFFF, 20'hFFFFF));
    send(make(otse_pkg::OP_ENCODE, 10'd1023, 32'h8000_0000, 20'h5A5A5));
    send(make(otse_pkg::OP_ENCODE, 10'd1023, 32'h8000_0000, 20'hA5A5A));
    send(make(otse_pkg::OP_ENCODE, 10'd0, 32'h0, 20'd3));
    send(make(otse_pkg::OP_COUNT, 10'd1023, 32'hFFFF_FFFF, 20'hFFFFF));
    settle();

    // multiclass with no prior weight and extreme priors
    reg_write(otse_pkg::REG_CLASS_CNT, 32'd4);
    reg_write(otse_pkg::REG_STRENGTH, 32'd0);
    reg_write(otse_pkg::REG_PRIOR0, 32'h7FFF_FFFF);
    reg_write(otse_pkg::REG_PRIOR1, 32'h8000_0000);
    reg_write(otse_pkg::REG_PRIOR2, 32'h0001_8000);
    reg_write(otse_pkg::REG_PRIOR3, 32'hFFFF_0000);
    send(make(otse_pkg::OP_ENCODE, 10'd5, 32'h0000_0000, 20'd10));
    send(make(otse_pkg::OP_ENCODE, 10'd5, 32'h0001_0000, 20'd11));
    send(make(otse_pkg::OP_ENCODE, 10'd5, 32'h0002_7FFF, 20'd12));
    send(make(otse_pkg::OP_ENCODE, 10'd5, 32'h0000_8000, 20'd13));
    send(make(otse_pkg::OP_ENCODE, 10'd5, 32'hFFFF_8000, 20'd14));
    send(make(otse_pkg::OP_ENCODE, 10'd5, 32'h0005_0000, 20'd15));
    send(make(otse_pkg::OP_ENCODE, 10'd5, 32'hFFFF_C000, 20'd16));
    settle();
    reg_write(otse_pkg::REG_STRENGTH, 32'hFFFF);
    // fill both queues with the receiver held off
    hold_request <= 1'b1;
    for (int i = 0; i < 15; i++) begin
      send(make(otse_pkg::OP_ENCODE, 10'(i % 3), $urandom, 20'(i)));
    end
    random_phase(15);
    settle();

    // class count out of range: seven acts as four, zero as one
    reg_write(otse_pkg::REG_CLASS_CNT, 32'd7);
    reg_write(otse_pkg::REG_STRENGTH, 32'd3);
    random_phase(15);
    settle();
    reg_write(otse_pkg::REG_CLASS_CNT, 32'd0);
    reg_write(otse_pkg::REG_PRIOR0, 32'h0000_8000);
    send(make(otse_pkg::OP_ENCODE, 10'd7, 32'h8000_0000, 20'd20));
    random_phase(15);
    settle();

    // frequency encoding, with high strength and then after six more count requests
    reg_write(otse_pkg::REG_CTR_MODE, 32'd1);
    reg_write(otse_pkg::REG_STRENGTH, 32'hFFFF);
    send(make(otse_pkg::OP_ENCODE, 10'd200, 32'd0, 20'd30));
    settle();
    reg_write(otse_pkg::REG_STRENGTH, 32'd0);
    for (int i = 0; i < 6; i++) send(make(otse_pkg::OP_COUNT, 10'(i % 2), $urandom, 20'(i)));
    random_phase(20);
    settle();
    reg_write(otse_pkg::REG_STRENGTH, 32'd2);
    reg_write(otse_pkg::REG_CLASS_CNT, 32'd2);
    random_phase(10);
    settle();

    $display("Sent %0d requests (%0d encodes) over mean and frequency settings,", sent,
             encodes);
    $display("checked %0d results, including a %0d-cycle receiver hold-off.", checked,
             HOLD_CYCLES);
    if (mismatches == 0 && awaiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
